### sv/voxel_neighborhood_symmetry_images_assert.svh
// assertion macros used by the top-level rtl file
`ifndef VOXEL_NEIGHBORHOOD_SYMMETRY_IMAGES_ASSERT_SVH
`define VOXEL_NEIGHBORHOOD_SYMMETRY_IMAGES_ASSERT_SVH

`ifndef SYNTHESIS
// checked on every rising edge, quiet while reset is high
`define VNS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every rising edge, reset included
`define VNS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define VNS_ASSERT(label, prop, msg)
`define VNS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### sv/vns_pkg.sv
`default_nettype none

package vns_pkg;

   localparam int CellCount = 27;
   localparam int ImageMax  = 48;

   // configuration port
   localparam int CsrAddrWidth = 1;
   localparam int CsrDataWidth = 32;
   localparam logic [CsrAddrWidth-1:0] AddrGroupSelect = 1'b0;

   // group select codes, anything above all-48 acts as all-48
   localparam logic [2:0] GroupFlip       = 3'd0;
   localparam logic [2:0] GroupRotate     = 3'd1;
   localparam logic [2:0] GroupDirect     = 3'd2;
   localparam logic [2:0] GroupFlipRotate = 3'd3;
   localparam logic [2:0] GroupAll        = 3'd4;

   // coordinates are offset by one: 0,1,2 stand for -1,0,1, so negation is 2-u
   function automatic logic [1:0] neg(input logic [1:0] u);
      return 2'd2 - u;
   endfunction

   // source cell that symmetry sym moves onto the destination cell (dx,dy,dz)
   // sym = (direction*4 + rotation)*2 + flip, undone in reverse order
   function automatic logic [4:0] src_cell(input logic [5:0] sym, input logic [1:0] dx,
                                           input logic [1:0] dy, input logic [1:0] dz);
      logic [1:0] x;
      logic [1:0] y;
      logic [1:0] z;
      logic [1:0] t;
      x = dx;
      y = dy;
      z = dz;
      // undo direction
      unique case (sym[5:3])
         3'd1: begin
            y = neg(y);
            z = neg(z);
         end
         3'd2: begin
            t = y;
            y = neg(z);
            z = t;
         end
         3'd3: begin
            t = y;
            y = z;
            z = neg(t);
         end
         3'd4: begin
            t = x;
            x = neg(z);
            z = t;
         end
         3'd5: begin
            t = x;
            x = z;
            z = neg(t);
         end
         default: begin
         end
      endcase
      // undo rotation about z
      unique case (sym[2:1])
         2'd1: begin
            t = x;
            x = y;
            y = neg(t);
         end
         2'd2: begin
            x = neg(x);
            y = neg(y);
         end
         2'd3: begin
            t = x;
            x = neg(y);
            y = t;
         end
         default: begin
         end
      endcase
      // undo flip
      if (sym[0]) begin
         x = neg(x);
      end
      return {3'b000, z} * 5'd9 + {3'b000, y} * 5'd3 + {3'b000, x};
   endfunction

endpackage

`default_nettype wire

### sv/voxel_neighborhood_symmetry_images.sv
// voxel neighbourhood symmetry images
//
// req channel: one transfer carries a 27-bit occupancy mask of a 3x3x3 block
// (bit n is cell (z+1)*9+(y+1)*3+(x+1)).
// rsp channel: for each mask, one transfer per image of the mask under the
// selected symmetry group, in index order, image 0 being the mask itself;
// is_last marks the final image, smaller_found / first_smaller track the first
// image after index 0 that is numerically below the mask.
// csr port: one register, group_select at byte address 0 (2, 4, 6, 8 or 48
// images; codes above 4 give all 48). reset value selects all 48.
// the mask is registered in the input register and each image in the output
// register. one image per cycle while rsp does not stall; a mask gives 2 to 48
// images, set by the group size; the next mask is taken in the same cycle the
// last image of the previous one moves to the output register.
// a stall on rsp holds the output register and the image counter; req is then
// stalled once the input register is busy.
// reset empties both registers and restores group_select; no transfer is lost
// or invented after it.

`default_nettype none

`include "voxel_neighborhood_symmetry_images_assert.svh"

module voxel_neighborhood_symmetry_images (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // mask in
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [vns_pkg::CellCount-1:0]        req_neighborhood,
   // images out
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [vns_pkg::CellCount-1:0]        rsp_image,
   output logic      [5:0]                           rsp_image_index,
   output logic                                      rsp_is_last,
   output logic                                      rsp_smaller_found,
   output logic      [vns_pkg::CellCount-1:0]        rsp_first_smaller,
   // register port
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [vns_pkg::CsrAddrWidth-1:0]     paddr,
   input  wire logic [vns_pkg::CsrDataWidth-1:0]     pwdata,
   output logic      [vns_pkg::CsrDataWidth-1:0]     prdata,
   output logic                                      pready
);

   logic [2:0] group_select;

   // input stage: mask being expanded, image counter, running search
   logic                           busy_ff, busy_in;
   logic [vns_pkg::CellCount-1:0]  mask_ff, mask_in;
   logic [5:0]                     idx_ff, idx_in;
   logic                           found_ff, found_in;
   logic [vns_pkg::CellCount-1:0]  first_ff, first_in;

   // output register
   logic                           out_valid_ff, out_valid_in;
   logic [vns_pkg::CellCount-1:0]  out_image_ff, out_image_in;
   logic [5:0]                     out_index_ff, out_index_in;
   logic                           out_last_ff, out_last_in;
   logic                           out_found_ff, out_found_in;
   logic [vns_pkg::CellCount-1:0]  out_first_ff, out_first_in;

   logic [5:0]                     last_idx;
   logic [5:0]                     sym;
   logic [vns_pkg::CellCount-1:0]  image;
   logic                           at_last;
   logic                           advance;
   logic                           req_accept;
   logic                           smaller;

   vns_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .group_select (group_select)
   );

   // group index to full symmetry number (direction*4 + rotation)*2 + flip
   always_comb begin
      unique case (group_select)
         vns_pkg::GroupFlip: begin
            last_idx = 6'd1;
            sym      = idx_ff;
         end
         vns_pkg::GroupRotate: begin
            last_idx = 6'd3;
            sym      = {idx_ff[4:0], 1'b0};
         end
         vns_pkg::GroupDirect: begin
            last_idx = 6'd5;
            sym      = {idx_ff[2:0], 3'b000};
         end
         vns_pkg::GroupFlipRotate: begin
            last_idx = 6'd7;
            sym      = idx_ff;
         end
         default: begin
            last_idx = 6'(vns_pkg::ImageMax - 1);
            sym      = idx_ff;
         end
      endcase
   end

   vns_image u_image (
      .mask  (mask_ff),
      .sym   (sym),
      .image (image)
   );

   // an image moves on when the output register is empty or being drained
   assign advance    = busy_ff && (!out_valid_ff || !rsp_stall);
   assign at_last    = (idx_ff == last_idx);
   assign req_stall  = busy_ff && !(advance && at_last);
   assign req_accept = req_valid && !req_stall;

   // identity never counts as a smaller image
   assign smaller = (idx_ff != 6'd0) && (image < mask_ff);

   always_comb begin
      busy_in  = busy_ff;
      mask_in  = mask_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      first_in = first_ff;
      if (advance) begin
         idx_in   = idx_ff + 6'd1;
         found_in = found_ff || smaller;
         if (!found_ff && smaller) begin
            first_in = image;
         end
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
      if (req_accept) begin
         busy_in  = 1'b1;
         mask_in  = req_neighborhood;
         idx_in   = 6'd0;
         found_in = 1'b0;
         first_in = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_image_in = out_image_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      out_found_in = out_found_ff;
      out_first_in = out_first_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_image_in = image;
         out_index_in = idx_ff;
         out_last_in  = at_last;
         out_found_in = found_ff || smaller;
         out_first_in = (!found_ff && smaller) ? image : first_ff;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mask_ff      <= mask_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      first_ff     <= first_in;
      out_image_ff <= out_image_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
      out_found_ff <= out_found_in;
      out_first_ff <= out_first_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_image         = out_image_ff;
   assign rsp_image_index   = out_index_ff;
   assign rsp_is_last       = out_last_ff;
   assign rsp_smaller_found = out_found_ff;
   assign rsp_first_smaller = out_first_ff;

   `VNS_ASSERT(a_identity_first, (out_valid_ff && out_index_ff == 6'd0) |-> (out_image_ff == mask_ff), "image 0 differs from the mask")
   `VNS_ASSERT(a_last_at_group_end, (out_valid_ff && out_last_ff) |-> (out_index_ff == last_idx), "last flag away from the group end")
   `VNS_ASSERT(a_index_steps, (advance && out_valid_ff && !out_last_ff) |=> (out_index_ff == $past(out_index_ff) + 6'd1), "image index skipped")
   `VNS_ASSERT(a_found_holds, (advance && out_valid_ff && !out_last_ff && out_found_ff) |=> out_found_ff, "smaller flag dropped within a mask")
   `VNS_ASSERT(a_first_zero_until_found, (out_valid_ff && !out_found_ff) |-> (out_first_ff == '0), "first smaller set before any hit")

endmodule

`default_nettype wire

### sv/vns_csr.sv
`default_nettype none

module vns_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [vns_pkg::CsrAddrWidth-1:0]     paddr,
   input  wire logic [vns_pkg::CsrDataWidth-1:0]     pwdata,
   output logic      [vns_pkg::CsrDataWidth-1:0]     prdata,
   output logic                                      pready,
   output logic      [2:0]                           group_select
);

   logic [2:0] group_ff;
   logic [2:0] group_in;
   logic       write_hit;

   assign pready    = 1'b1;
   assign write_hit = psel && penable && pwrite && (paddr == vns_pkg::AddrGroupSelect);

   always_comb begin
      group_in = group_ff;
      if (write_hit) begin
         group_in = pwdata[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= vns_pkg::GroupAll;
      end else begin
         group_ff <= group_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == vns_pkg::AddrGroupSelect) begin
         prdata = {{(vns_pkg::CsrDataWidth-3){1'b0}}, group_ff};
      end
   end

   assign group_select = group_ff;

endmodule

`default_nettype wire

### sv/vns_image.sv
`default_nettype none

module vns_image (
   input  wire logic [vns_pkg::CellCount-1:0] mask,
   input  wire logic [5:0]                    sym,
   output logic      [vns_pkg::CellCount-1:0] image
);

   // each destination cell picks its source cell through a small lookup on sym
   for (genvar gz = 0; gz < 3; gz++) begin : g_z
      for (genvar gy = 0; gy < 3; gy++) begin : g_y
         for (genvar gx = 0; gx < 3; gx++) begin : g_x
            localparam int Cell = gz * 9 + gy * 3 + gx;
            assign image[Cell] = mask[vns_pkg::src_cell(sym, 2'(gx), 2'(gy), 2'(gz))];
         end
      end
   end

endmodule

`default_nettype wire
